// ----- hdl/zyz_pkg.sv -----
package zyz_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STAGES     = 28;
  localparam int INT_FRAC          = 30;
  // Q2.30 with guard bits for CORDIC growth
  localparam int XW                = 34;
  localparam int ZW                = 33;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic signed [XW-1:0] fix_t;

  // arctangent of 2^-i as a 32-bit phase
  function automatic logic signed [ZW-1:0] atan_phase(input int i);
    logic [31:0] v;
    begin
      unique case (i)
        0:  v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
        3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
        6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
        9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
        12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
        15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
        18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
        21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
        24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
        27: v = 32'h00000005;
        default: v = 32'h0;
      endcase
      atan_phase = $signed({1'b0, v});
    end
  endfunction

  // round-half-up Q2.30 product
  function automatic fix_t qmul(input fix_t a, input fix_t b);
    logic signed [2*XW-1:0] p;
    begin
      p = a * b + (68'sd1 <<< (INT_FRAC - 1));
      qmul = fix_t'(p >>> INT_FRAC);
    end
  endfunction

endpackage

// ----- hdl/zyz_cell.sv -----
module zyz_cell
  import zyz_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  fix_t                  x_in  [3],
  input  fix_t                  y_in  [3],
  input  logic signed [ZW-1:0]  z_in  [3],
  input  logic [2:0]            flip_in,
  output fix_t                  x_out [3],
  output fix_t                  y_out [3],
  output logic signed [ZW-1:0]  z_out [3],
  output logic [2:0]            flip_out
);

  localparam logic signed [ZW-1:0] ATAN = atan_phase(STAGE);

  fix_t                 x_r [3], x_nxt [3];
  fix_t                 y_r [3], y_nxt [3];
  logic signed [ZW-1:0] z_r [3], z_nxt [3];
  logic [2:0]           flip_r;

  // one micro-rotation for each of the three angles
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!z_in[k][ZW-1]) begin
        x_nxt[k] = x_in[k] - (y_in[k] >>> STAGE);
        y_nxt[k] = y_in[k] + (x_in[k] >>> STAGE);
        z_nxt[k] = z_in[k] - ATAN;
      end else begin
        x_nxt[k] = x_in[k] + (y_in[k] >>> STAGE);
        y_nxt[k] = y_in[k] - (x_in[k] >>> STAGE);
        z_nxt[k] = z_in[k] + ATAN;
      end
    end
  end

  // advance when the chain moves
  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      flip_r <= flip_in;
    end
  end

  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign flip_out = flip_r;

endmodule

// ----- hdl/zyz_mat.sv -----
module zyz_mat
  import zyz_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  fix_t                      sn [3],
  input  fix_t                      cs [3],
  output logic [OUT_FRAC_BITS+1:0]  ent [9]
);

  localparam int OW = OUT_FRAC_BITS + 2;
  localparam int SH = INT_FRAC - OUT_FRAC_BITS;

  fix_t sa_r, ca_r, sb_r, cb_r, sg_r, cg_r, cbca_r, cbsa_r;
  fix_t p_r [12];
  fix_t sum [9];

  function automatic logic [OW-1:0] to_out(input fix_t v);
    fix_t r, one;
    begin
      one = fix_t'(1) <<< OUT_FRAC_BITS;
      if (SH > 0) r = (v + ((fix_t'(1) <<< SH) >>> 1)) >>> SH;
      else        r = v;
      if (r > one)  r = one;
      if (r < -one) r = -one;
      to_out = r[OW-1:0];
    end
  endfunction

  // stage one: cb products, hold the sines and cosines
  always_ff @(posedge clk) begin
    if (en) begin
      sa_r <= sn[0]; ca_r <= cs[0];
      sb_r <= sn[1]; cb_r <= cs[1];
      sg_r <= sn[2]; cg_r <= cs[2];
      cbca_r <= qmul(cs[1], cs[0]);
      cbsa_r <= qmul(cs[1], sn[0]);
    end
  end

  // stage two: remaining products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= qmul(cg_r, cbca_r);
      p_r[1]  <= qmul(sg_r, sa_r);
      p_r[2]  <= qmul(sg_r, cbca_r);
      p_r[3]  <= qmul(cg_r, sa_r);
      p_r[4]  <= qmul(sb_r, ca_r);
      p_r[5]  <= qmul(cg_r, cbsa_r);
      p_r[6]  <= qmul(sg_r, ca_r);
      p_r[7]  <= qmul(sg_r, cbsa_r);
      p_r[8]  <= qmul(cg_r, ca_r);
      p_r[9]  <= qmul(sb_r, sa_r);
      p_r[10] <= qmul(cg_r, sb_r);
      p_r[11] <= qmul(sg_r, sb_r);
    end
  end

  fix_t cb2_r;
  always_ff @(posedge clk) begin
    if (en) cb2_r <= cb_r;
  end

  // stage three: sums, round, saturate
  always_comb begin
    sum[0] = p_r[0] - p_r[1];
    sum[1] = p_r[2] + p_r[3];
    sum[2] = -p_r[4];
    sum[3] = -p_r[5] - p_r[6];
    sum[4] = p_r[8] - p_r[7];
    sum[5] = p_r[9];
    sum[6] = p_r[10];
    sum[7] = p_r[11];
    sum[8] = cb2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) ent[k] <= to_out(sum[k]);
    end
  end

endmodule

// ----- hdl/zyz_euler_to_rotation_matrix.sv -----
// ZYZ Euler angles to rotation matrix.
// Path: quadrant fold and entry register, then the 28-cell CORDIC chain,
//   one micro-rotation per cell, and three product/sum stages behind it.
// Throughput: one word per cycle unless a finished word waits on out_stall.
// Reset: synchronous active-low rst_n clears the valid bits of the chain.
module zyz_euler_to_rotation_matrix
  import zyz_pkg::*;
#(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ANGLE_BITS-1:0]      in_alpha_angle,
  input  logic signed [ANGLE_BITS-1:0]      in_beta_angle,
  input  logic signed [ANGLE_BITS-1:0]      in_gamma_angle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [OUT_FRAC_BITS+1:0]   out_row0_col0,
  output logic signed [OUT_FRAC_BITS+1:0]   out_row1_col0,
  output logic signed [OUT_FRAC_BITS+1:0]   out_row2_col0,
  output logic signed [OUT_FRAC_BITS+1:0]   out_row0_col1,
  output logic signed [OUT_FRAC_BITS+1:0]   out_row1_col1,
  output logic signed [OUT_FRAC_BITS+1:0]   out_row2_col1,
  output logic signed [OUT_FRAC_BITS+1:0]   out_row0_col2,
  output logic signed [OUT_FRAC_BITS+1:0]   out_row1_col2,
  output logic signed [OUT_FRAC_BITS+1:0]   out_row2_col2
);

  localparam int LAT = CORDIC_STAGES + 4;
  localparam int OW  = OUT_FRAC_BITS + 2;

  logic [LAT-1:0] vld_r;
  logic           en;

  // the whole pipe moves unless a finished word waits on a stalled output
  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
  end

  // quadrant fold and entry registers
  logic [ANGLE_BITS-1:0] ang [3];
  fix_t                  x0 [3], y0 [3];
  logic signed [ZW-1:0]  z0 [3];
  logic [2:0]            f0;
  fix_t                  xc [CORDIC_STAGES+1][3];
  fix_t                  yc [CORDIC_STAGES+1][3];
  logic signed [ZW-1:0]  zc [CORDIC_STAGES+1][3];
  logic [2:0]            fc [CORDIC_STAGES+1];

  assign ang[0] = in_alpha_angle;
  assign ang[1] = in_beta_angle;
  assign ang[2] = in_gamma_angle;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [31:0] p;
      p = {ang[k], {(32-ANGLE_BITS){1'b0}}};
      f0[k] = p[31] ^ p[30];
      if (f0[k]) p = p + 32'h80000000;
      z0[k] = {p[31], p};
      x0[k] = CORDIC_GAIN;
      y0[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xc[0] <= x0; yc[0] <= y0; zc[0] <= z0; fc[0] <= f0;
    end
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
    zyz_cell #(.STAGE(s)) u_cell (
      .clk(clk), .en(en),
      .x_in(xc[s]), .y_in(yc[s]), .z_in(zc[s]), .flip_in(fc[s]),
      .x_out(xc[s+1]), .y_out(yc[s+1]), .z_out(zc[s+1]), .flip_out(fc[s+1])
    );
  end

  // undo the fold
  fix_t sn [3], cs [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sn[k] = fc[CORDIC_STAGES][k] ? -yc[CORDIC_STAGES][k] : yc[CORDIC_STAGES][k];
      cs[k] = fc[CORDIC_STAGES][k] ? -xc[CORDIC_STAGES][k] : xc[CORDIC_STAGES][k];
    end
  end

  logic [OW-1:0] ent [9];
  zyz_mat #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (
    .clk(clk), .en(en), .sn(sn), .cs(cs), .ent(ent)
  );

  assign out_row0_col0 = ent[0];
  assign out_row1_col0 = ent[1];
  assign out_row2_col0 = ent[2];
  assign out_row0_col1 = ent[3];
  assign out_row1_col1 = ent[4];
  assign out_row2_col1 = ent[5];
  assign out_row0_col2 = ent[6];
  assign out_row1_col2 = ent[7];
  assign out_row2_col2 = ent[8];

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row0_col0))
    else $error("output word changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall && vld_r[LAT-2] |=> out_valid)
    else $error("word lost in chain");
`endif

endmodule
